// ===== hw/rtl/maxrects_rect_packer_macros.svh =====
// assertion macros used by the checker file
`ifndef MAXRECTS_RECT_PACKER_MACROS_SVH
`define MAXRECTS_RECT_PACKER_MACROS_SVH

// same-cycle implication
`define MRP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mrp check failed");

// next-cycle implication
`define MRP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mrp check failed");

`endif

// ===== hw/rtl/mrp_pkg.sv =====
// ----------------------------------------------------------------------------
// mrp_pkg
// shared types and codes of the maxrects rectangle packer
// ----------------------------------------------------------------------------
package mrp_pkg;

  localparam int unsigned FieldDimBits = 14;
  localparam int unsigned CfgIdxBits   = 2;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] CFG_BIN_WIDTH    = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_BIN_HEIGHT   = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_MULTIPLE_BINS = 2'd2;

  typedef enum logic [2:0] {
    ST_PLACED    = 3'd0,
    ST_NEW_BIN   = 3'd1,
    ST_NO_ROOM   = 3'd2,
    ST_SKIPPED   = 3'd3,
    ST_TOO_LARGE = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_e;

  typedef struct packed {
    logic [FieldDimBits-1:0] rect_width;
    logic [FieldDimBits-1:0] rect_height;
    logic                    end_of_batch;
  } in_word_t;

  typedef struct packed {
    logic [12:0] pos_x;
    logic [12:0] pos_y;
    logic [15:0] bin_index;
    logic [2:0]  status;
    logic [23:0] placed_count;
  } out_word_t;

  // results of the shared geometry unit
  typedef struct packed {
    logic       overlap;
    logic       contains;
    logic [3:0] piece_mask;
  } geom_flags_t;

endpackage

// ===== hw/rtl/mrp_ram.sv =====
// ----------------------------------------------------------------------------
// mrp_ram
// generic one-write one-read memory with registered read data
// ----------------------------------------------------------------------------
module mrp_ram #(
  parameter int unsigned WIDTH = 56,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mrp_geom.sv =====
// ----------------------------------------------------------------------------
// mrp_geom
// shared rectangle compare unit: overlap, containment and split pieces
// ----------------------------------------------------------------------------
module mrp_geom #(
  parameter int unsigned COORD_BITS = 14
) (
  input  logic [4*COORD_BITS-1:0]       a_i,
  input  logic [4*COORD_BITS-1:0]       b_i,
  output mrp_pkg::geom_flags_t          flags_o,
  output logic [3:0][4*COORD_BITS-1:0]  pieces_o
);

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } box_t;

  box_t a, b;
  logic [COORD_BITS:0] ax, ay, bx, by, ar, ab, br, bb;
  logic ov_x, ov_y;

  assign a  = a_i;
  assign b  = b_i;
  assign ax = {1'b0, a.x};
  assign ay = {1'b0, a.y};
  assign bx = {1'b0, b.x};
  assign by = {1'b0, b.y};
  assign ar = ax + {1'b0, a.w};
  assign ab = ay + {1'b0, a.h};
  assign br = bx + {1'b0, b.w};
  assign bb = by + {1'b0, b.h};

  assign ov_x = (bx < ar) && (br > ax);
  assign ov_y = (by < ab) && (bb > ay);

  assign flags_o.overlap  = ov_x && ov_y;
  // b lies inside a
  assign flags_o.contains = (bx >= ax) && (br <= ar) && (by >= ay) && (bb <= ab);

  // pieces in push order: below, above, left, right
  assign flags_o.piece_mask[0] = ov_x && (bb < ab);
  assign flags_o.piece_mask[1] = ov_x && (by > ay) && (by < ab);
  assign flags_o.piece_mask[2] = ov_y && (bx > ax) && (bx < ar);
  assign flags_o.piece_mask[3] = ov_y && (br < ar);

  assign pieces_o[0] = {a.x, COORD_BITS'(bb), a.w, COORD_BITS'(ab - bb)};
  assign pieces_o[1] = {a.x, a.y, a.w, COORD_BITS'(by - ay)};
  assign pieces_o[2] = {a.x, a.y, COORD_BITS'(bx - ax), a.h};
  assign pieces_o[3] = {COORD_BITS'(br), a.y, COORD_BITS'(ar - br), a.h};

endmodule

// ===== hw/rtl/maxrects_rect_packer.sv =====
// ----------------------------------------------------------------------------
// maxrects_rect_packer
// maxrects bin packer, best area fit with shorter-leftover-side tie break
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o move one word (rectangle size plus
//   end-of-batch mark); output channel: out_valid_o / out_stall_i move one
//   result word per input word
// config channel: cfg_valid_i / cfg_ready_o, index and data; write only while
//   no word is in flight; a bin size write reloads the free list
// per word, in order: best-fit scan of the free rectangles, split of every
//   overlapped entry into new pieces, pruning piece against piece, then kept
//   entry against piece, and compaction; a second scan is added when a fresh
//   bin opens; skipped words go straight to the result
// throughput: one word at a time; the pruning pass over the single shared
//   geometry unit and the one read port of each list memory set the pace
// reset: bin 1024 x 1024, single-bin mode, counters clear; the first cycle
//   after reset writes the whole bin into free entry 0 and stalls the input
// a stalled result stays in the output register; the next word is taken in
//   meanwhile, and only its own result waits for the register to empty
// ----------------------------------------------------------------------------
module maxrects_rect_packer #(
  parameter int unsigned MAX_FREE_RECTS = 64,
  parameter int unsigned COORD_BITS     = 14
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  mrp_pkg::in_word_t                   in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output mrp_pkg::out_word_t                  out_word_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mrp_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [mrp_pkg::FieldDimBits-1:0]    cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_FREE_RECTS);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned BW = 4 * COORD_BITS;
  localparam int unsigned PW = 2 * COORD_BITS;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_FREE_RECTS);
  localparam logic [CW-1:0] OneCnt = CW'(1);
  localparam logic [COORD_BITS-1:0] OneC   = COORD_BITS'(1);
  localparam logic [COORD_BITS-1:0] BinMax = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [COORD_BITS-1:0] DefDim = COORD_BITS'(1024);

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } box_t;

  typedef enum logic [17:0] {
    S_INIT    = 18'h00001,
    S_IDLE    = 18'h00002,
    S_PRE     = 18'h00004,
    S_SC_RD   = 18'h00008,
    S_SC_MUL  = 18'h00010,
    S_SC_CMP  = 18'h00020,
    S_SP_RD   = 18'h00040,
    S_SP_CHK  = 18'h00080,
    S_SP_PUSH = 18'h00100,
    S_PR_RDA  = 18'h00200,
    S_PR_GETA = 18'h00400,
    S_PR_RDB  = 18'h00800,
    S_PR_CMP  = 18'h01000,
    S_CP_RD   = 18'h02000,
    S_CP_WR   = 18'h04000,
    S_CN_RD   = 18'h08000,
    S_CN_WR   = 18'h10000,
    S_DONE    = 18'h20000
  } state_e;

  function automatic logic [COORD_BITS-1:0] fix_zero(input logic [COORD_BITS-1:0] v);
    return (v == '0) ? OneC : v;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_bin(input logic [COORD_BITS-1:0] v);
    logic [COORD_BITS-1:0] t;
    t = fix_zero(v);
    return (t > BinMax) ? BinMax : t;
  endfunction

  // control state
  state_e                state_q, state_d;
  logic [COORD_BITS-1:0] bw_q, bw_d, bh_q, bh_d;
  logic                  multi_q, multi_d;
  logic [CW-1:0]         free_cnt_q, free_cnt_d, new_cnt_q, new_cnt_d, k_q, k_d;
  logic [CW-1:0]         i_q, i_d, j_q, j_d;
  logic [MAX_FREE_RECTS-1:0] keep_q, keep_d, nvalid_q, nvalid_d;
  logic                  found_q, found_d, fresh_q, fresh_d, lost_q, lost_d;
  logic                  pr_free_q, pr_free_d;
  logic [15:0]           bin_cnt_q, bin_cnt_d;
  logic [23:0]           placed_q, placed_d;
  logic                  stopped_q, stopped_d;
  logic                  out_valid_q, out_valid_d;

  // payload
  logic [COORD_BITS-1:0] rw_q, rw_d, rh_q, rh_d, bx_q, bx_d, by_q, by_d;
  logic [COORD_BITS-1:0] px_q, px_d, py_q, py_d, best_short_q, best_short_d;
  logic                  eob_q, eob_d, fit_q, fit_d;
  logic [PW-1:0]         wh_q, wh_d, prod_q, prod_d, best_area_q, best_area_d;
  box_t                  fbox_q, fbox_d, a_q, a_d;
  logic [3:0][BW-1:0]    pieces_q, pieces_d;
  logic [3:0]            pmask_q, pmask_d;
  mrp_pkg::status_e      status_q, status_d;
  mrp_pkg::out_word_t    out_q, out_d;

  // memories
  logic          f_we, n_we;
  logic [IW-1:0] f_waddr, f_raddr, n_waddr, n_raddr;
  logic [BW-1:0] f_wdata, f_rdata, n_wdata, n_rdata;
  box_t          f_box;

  // shared geometry unit
  logic [BW-1:0]        g_a, g_b;
  mrp_pkg::geom_flags_t g_flags;
  logic [3:0][BW-1:0]   g_pieces;

  // scan scoring
  logic [PW-1:0]         area;
  logic [COORD_BITS-1:0] dw, dh, short_side;
  logic                  better;
  logic [1:0]            psel;
  logic [CW-1:0]         pr_limit;
  logic                  pr_avalid;
  logic [COORD_BITS-1:0] cfg_dim;

  mrp_ram #(.WIDTH(BW), .DEPTH(MAX_FREE_RECTS)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  mrp_ram #(.WIDTH(BW), .DEPTH(MAX_FREE_RECTS)) u_new_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .raddr_i (n_raddr),
    .rdata_o (n_rdata)
  );

  // split uses the free entry against the placed rectangle, pruning uses the
  // held entry against a new piece
  assign g_a = (state_q == S_SP_CHK) ? f_rdata : a_q;
  assign g_b = (state_q == S_SP_CHK) ? {bx_q, by_q, rw_q, rh_q} : n_rdata;

  mrp_geom #(.COORD_BITS(COORD_BITS)) u_geom (
    .a_i      (g_a),
    .b_i      (g_b),
    .flags_o  (g_flags),
    .pieces_o (g_pieces)
  );

  assign f_box      = f_rdata;
  assign area       = prod_q - wh_q;
  assign dw         = fbox_q.w - rw_q;
  assign dh         = fbox_q.h - rh_q;
  assign short_side = (dw < dh) ? dw : dh;
  assign better     = fit_q && (!found_q || (area < best_area_q) ||
                      ((area == best_area_q) && (short_side < best_short_q)));

  // lowest pending piece goes first
  always_comb begin
    psel = 2'd0;
    for (int p = 3; p >= 0; p--) begin
      if (pmask_q[p]) psel = 2'(p);
    end
  end

  assign pr_limit  = pr_free_q ? free_cnt_q : new_cnt_q;
  assign pr_avalid = pr_free_q ? keep_q[i_q[IW-1:0]] : nvalid_q[i_q[IW-1:0]];
  assign cfg_dim   = clamp_bin(COORD_BITS'(cfg_data_i));

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    state_d      = state_q;
    bw_d         = bw_q;
    bh_d         = bh_q;
    multi_d      = multi_q;
    free_cnt_d   = free_cnt_q;
    new_cnt_d    = new_cnt_q;
    k_d          = k_q;
    i_d          = i_q;
    j_d          = j_q;
    keep_d       = keep_q;
    nvalid_d     = nvalid_q;
    found_d      = found_q;
    fresh_d      = fresh_q;
    lost_d       = lost_q;
    pr_free_d    = pr_free_q;
    bin_cnt_d    = bin_cnt_q;
    placed_d     = placed_q;
    stopped_d    = stopped_q;
    out_valid_d  = out_valid_q;
    rw_d         = rw_q;
    rh_d         = rh_q;
    bx_d         = bx_q;
    by_d         = by_q;
    px_d         = px_q;
    py_d         = py_q;
    best_short_d = best_short_q;
    best_area_d  = best_area_q;
    eob_d        = eob_q;
    fit_d        = fit_q;
    wh_d         = wh_q;
    prod_d       = prod_q;
    fbox_d       = fbox_q;
    a_d          = a_q;
    pieces_d     = pieces_q;
    pmask_d      = pmask_q;
    status_d     = status_q;
    out_d        = out_q;
    f_we         = 1'b0;
    f_waddr      = k_q[IW-1:0];
    f_wdata      = f_rdata;
    f_raddr      = i_q[IW-1:0];
    n_we         = 1'b0;
    n_waddr      = new_cnt_q[IW-1:0];
    n_wdata      = pieces_q[psel];
    n_raddr      = j_q[IW-1:0];

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    // configuration writes, only while idle
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mrp_pkg::CFG_BIN_WIDTH: begin
          bw_d       = cfg_dim;
          f_we       = 1'b1;
          f_waddr    = '0;
          f_wdata    = {{(2*COORD_BITS){1'b0}}, cfg_dim, bh_q};
          free_cnt_d = OneCnt;
        end
        mrp_pkg::CFG_BIN_HEIGHT: begin
          bh_d       = cfg_dim;
          f_we       = 1'b1;
          f_waddr    = '0;
          f_wdata    = {{(2*COORD_BITS){1'b0}}, bw_q, cfg_dim};
          free_cnt_d = OneCnt;
        end
        mrp_pkg::CFG_MULTIPLE_BINS: multi_d = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      // free entry 0 gets the whole bin once after reset
      S_INIT: begin
        f_we    = 1'b1;
        f_waddr = '0;
        f_wdata = {{(2*COORD_BITS){1'b0}}, bw_q, bh_q};
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          rw_d    = fix_zero(COORD_BITS'(in_word_i.rect_width));
          rh_d    = fix_zero(COORD_BITS'(in_word_i.rect_height));
          eob_d   = in_word_i.end_of_batch;
          px_d    = '0;
          py_d    = '0;
          fresh_d = 1'b0;
          lost_d  = 1'b0;
          if (stopped_q) begin
            status_d = mrp_pkg::ST_SKIPPED;
            state_d  = S_DONE;
          end else begin
            state_d = S_PRE;
          end
        end
      end
      S_PRE: begin
        wh_d    = PW'(rw_q) * PW'(rh_q);
        i_d     = '0;
        found_d = 1'b0;
        state_d = S_SC_RD;
      end
      // best-fit scan, one free entry per pass through the read, multiply and compare states
      S_SC_RD: begin
        if (i_q == free_cnt_q) begin
          if (found_q) begin
            i_d       = '0;
            new_cnt_d = '0;
            nvalid_d  = '0;
            keep_d    = '1;
            px_d      = bx_q;
            py_d      = by_q;
            state_d   = S_SP_RD;
          end else if (!multi_q) begin
            status_d  = mrp_pkg::ST_NO_ROOM;
            stopped_d = 1'b1;
            state_d   = S_DONE;
          end else if (fresh_q) begin
            status_d = mrp_pkg::ST_TOO_LARGE;
            state_d  = S_DONE;
          end else begin
            // open a fresh bin and scan again
            f_we       = 1'b1;
            f_waddr    = '0;
            f_wdata    = {{(2*COORD_BITS){1'b0}}, bw_q, bh_q};
            free_cnt_d = OneCnt;
            if (bin_cnt_q != 16'hFFFF) bin_cnt_d = bin_cnt_q + 16'd1;
            fresh_d    = 1'b1;
            i_d        = '0;
          end
        end else begin
          state_d = S_SC_MUL;
        end
      end
      S_SC_MUL: begin
        fbox_d  = f_box;
        fit_d   = (rw_q <= f_box.w) && (rh_q <= f_box.h);
        prod_d  = PW'(f_box.w) * PW'(f_box.h);
        state_d = S_SC_CMP;
      end
      S_SC_CMP: begin
        if (better) begin
          found_d      = 1'b1;
          best_area_d  = area;
          best_short_d = short_side;
          bx_d         = fbox_q.x;
          by_d         = fbox_q.y;
        end
        i_d     = i_q + OneCnt;
        state_d = S_SC_RD;
      end
      // split every overlapped free entry
      S_SP_RD: begin
        if (i_q == free_cnt_q) begin
          i_d       = '0;
          pr_free_d = 1'b0;
          state_d   = S_PR_RDA;
        end else begin
          state_d = S_SP_CHK;
        end
      end
      S_SP_CHK: begin
        if (g_flags.overlap) begin
          keep_d[i_q[IW-1:0]] = 1'b0;
          pieces_d = g_pieces;
          pmask_d  = g_flags.piece_mask;
          state_d  = S_SP_PUSH;
        end else begin
          i_d     = i_q + OneCnt;
          state_d = S_SP_RD;
        end
      end
      S_SP_PUSH: begin
        if (pmask_q == '0) begin
          i_d     = i_q + OneCnt;
          state_d = S_SP_RD;
        end else begin
          pmask_d[psel] = 1'b0;
          if (new_cnt_q < MaxCnt) begin
            n_we = 1'b1;
            nvalid_d[new_cnt_q[IW-1:0]] = 1'b1;
            new_cnt_d = new_cnt_q + OneCnt;
          end else begin
            lost_d = 1'b1;
          end
        end
      end
      // prune pieces held inside another piece, then inside a kept entry
      S_PR_RDA: begin
        if (i_q == pr_limit) begin
          i_d = '0;
          if (!pr_free_q) begin
            pr_free_d = 1'b1;
          end else begin
            k_d     = '0;
            state_d = S_CP_RD;
          end
        end else if (!pr_avalid) begin
          i_d = i_q + OneCnt;
        end else begin
          n_raddr = i_q[IW-1:0];
          state_d = S_PR_GETA;
        end
      end
      S_PR_GETA: begin
        a_d     = pr_free_q ? f_rdata : n_rdata;
        j_d     = '0;
        state_d = S_PR_RDB;
      end
      S_PR_RDB: begin
        if (j_q == new_cnt_q) begin
          i_d     = i_q + OneCnt;
          state_d = S_PR_RDA;
        end else if (!nvalid_q[j_q[IW-1:0]] || (!pr_free_q && (j_q == i_q))) begin
          j_d = j_q + OneCnt;
        end else begin
          state_d = S_PR_CMP;
        end
      end
      S_PR_CMP: begin
        if (g_flags.contains) nvalid_d[j_q[IW-1:0]] = 1'b0;
        j_d     = j_q + OneCnt;
        state_d = S_PR_RDB;
      end
      // compact kept entries, then append surviving pieces
      S_CP_RD: begin
        if (i_q == free_cnt_q) begin
          j_d     = '0;
          state_d = S_CN_RD;
        end else if (!keep_q[i_q[IW-1:0]]) begin
          i_d = i_q + OneCnt;
        end else begin
          state_d = S_CP_WR;
        end
      end
      S_CP_WR: begin
        f_we    = 1'b1;
        k_d     = k_q + OneCnt;
        i_d     = i_q + OneCnt;
        state_d = S_CP_RD;
      end
      S_CN_RD: begin
        if (j_q == new_cnt_q) begin
          free_cnt_d = k_q;
          if (lost_q) status_d = mrp_pkg::ST_OVERFLOW;
          else if (fresh_q) status_d = mrp_pkg::ST_NEW_BIN;
          else status_d = mrp_pkg::ST_PLACED;
          if (placed_q != 24'hFFFFFF) placed_d = placed_q + 24'd1;
          state_d = S_DONE;
        end else if (!nvalid_q[j_q[IW-1:0]]) begin
          j_d = j_q + OneCnt;
        end else if (k_q == MaxCnt) begin
          lost_d = 1'b1;
          j_d    = j_q + OneCnt;
        end else begin
          state_d = S_CN_WR;
        end
      end
      S_CN_WR: begin
        f_we    = 1'b1;
        f_wdata = n_rdata;
        k_d     = k_q + OneCnt;
        j_d     = j_q + OneCnt;
        state_d = S_CN_RD;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.pos_x        = 13'(px_q);
          out_d.pos_y        = 13'(py_q);
          out_d.bin_index    = bin_cnt_q;
          out_d.status       = status_q;
          out_d.placed_count = placed_q;
          out_valid_d        = 1'b1;
          if (eob_q) begin
            bin_cnt_d = '0;
            stopped_d = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      bw_q        <= DefDim;
      bh_q        <= DefDim;
      multi_q     <= 1'b0;
      free_cnt_q  <= OneCnt;
      new_cnt_q   <= '0;
      k_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      keep_q      <= '0;
      nvalid_q    <= '0;
      found_q     <= 1'b0;
      fresh_q     <= 1'b0;
      lost_q      <= 1'b0;
      pr_free_q   <= 1'b0;
      bin_cnt_q   <= '0;
      placed_q    <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bw_q        <= bw_d;
      bh_q        <= bh_d;
      multi_q     <= multi_d;
      free_cnt_q  <= free_cnt_d;
      new_cnt_q   <= new_cnt_d;
      k_q         <= k_d;
      i_q         <= i_d;
      j_q         <= j_d;
      keep_q      <= keep_d;
      nvalid_q    <= nvalid_d;
      found_q     <= found_d;
      fresh_q     <= fresh_d;
      lost_q      <= lost_d;
      pr_free_q   <= pr_free_d;
      bin_cnt_q   <= bin_cnt_d;
      placed_q    <= placed_d;
      stopped_q   <= stopped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rw_q         <= rw_d;
    rh_q         <= rh_d;
    bx_q         <= bx_d;
    by_q         <= by_d;
    px_q         <= px_d;
    py_q         <= py_d;
    best_short_q <= best_short_d;
    best_area_q  <= best_area_d;
    eob_q        <= eob_d;
    fit_q        <= fit_d;
    wh_q         <= wh_d;
    prod_q       <= prod_d;
    fbox_q       <= fbox_d;
    a_q          <= a_d;
    pieces_q     <= pieces_d;
    pmask_q      <= pmask_d;
    status_q     <= status_d;
    out_q        <= out_d;
  end

  // the free list memory is written as a fresh bin opens too (entry 0);
  // the scan rereads it on the next pass

endmodule

// ===== hw/rtl/mrp_checker.sv =====
// ----------------------------------------------------------------------------
// mrp_checker
// port-level checks of the maxrects rectangle packer
// ----------------------------------------------------------------------------
`include "maxrects_rect_packer_macros.svh"

module mrp_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input mrp_pkg::out_word_t               out_word_o,
  input logic                             cfg_ready_o
);

  // a held result keeps its word
  `MRP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o))

  // every accepted word keeps the block busy in the cycle after it is taken
  `MRP_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // no configuration while a word is in flight
  `MRP_ASSERT_NXT(a_no_cfg_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, !cfg_ready_o)

  // unplaced results carry a zero position
  `MRP_ASSERT_IMP(a_unplaced_zero, clk_i, rst_ni, out_valid_o && ((out_word_o.status == mrp_pkg::ST_NO_ROOM) || (out_word_o.status == mrp_pkg::ST_SKIPPED) || (out_word_o.status == mrp_pkg::ST_TOO_LARGE)), (out_word_o.pos_x == 13'd0) && (out_word_o.pos_y == 13'd0))

endmodule

bind maxrects_rect_packer mrp_checker u_mrp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o),
  .cfg_ready_o (cfg_ready_o)
);

// ===== tb/sv/maxrects_rect_packer_tb.sv =====
// ----------------------------------------------------------------------------
// maxrects_rect_packer_tb
// self-checking bench for the maxrects packer: a behavioral packer tracks the
// free list per accepted word and every result word is compared field by field
// ----------------------------------------------------------------------------
module maxrects_rect_packer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FreeDepth = 64;
  localparam int unsigned BinMax    = 8192;
  localparam int unsigned DimMask   = 16'h3fff;
  localparam int unsigned IdleLimit = 200000;
  // index that decodes to no register
  localparam logic [mrp_pkg::CfgIdxBits-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    int unsigned x, y, w, h;
  } box_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_stall_o;
  mrp_pkg::in_word_t                in_word_i;
  logic                             out_valid_o;
  logic                             out_stall_i;
  mrp_pkg::out_word_t               out_word_o;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [mrp_pkg::CfgIdxBits-1:0]   cfg_index_i;
  logic [mrp_pkg::FieldDimBits-1:0] cfg_data_i;

  maxrects_rect_packer dut (.*);

  // packer state as the bench sees it
  int unsigned bin_w, bin_h;
  bit          multi_bin;
  box_t        free_box [FreeDepth];
  bit          free_ok  [FreeDepth];
  box_t        piece_box[FreeDepth];
  bit          piece_ok [FreeDepth];
  int unsigned piece_cnt;
  bit          piece_dropped;
  int unsigned bin_cnt, placed_cnt;
  bit          batch_halted;

  mrp_pkg::in_word_t  size_queue[$];
  mrp_pkg::out_word_t result_queue[$];
  int                 in_gap, out_gap;
  int unsigned        idle_cycles;
  bit                 failed;

  // ---- behavioral packer ---------------------------------------------------

  function automatic int unsigned clamp_dim(int unsigned v);
    int unsigned d;
    d = v & DimMask;
    if (d == 0) d = 1;
    if (d > BinMax) d = BinMax;
    return d;
  endfunction

  // free list back to one entry spanning the bin
  function automatic void reload_bin();
    foreach (free_ok[i]) free_ok[i] = 1'b0;
    free_box[0] = '{0, 0, bin_w, bin_h};
    free_ok[0]  = 1'b1;
  endfunction

  function automatic bit overlaps(box_t a, box_t b);
    return b.x < a.x + a.w && b.x + b.w > a.x && b.y < a.y + a.h && b.y + b.h > a.y;
  endfunction

  // b lies inside a
  function automatic bit covers(box_t a, box_t b);
    return b.x >= a.x && b.x + b.w <= a.x + a.w && b.y >= a.y && b.y + b.h <= a.y + a.h;
  endfunction

  function automatic void add_piece(int unsigned x, int unsigned y, int unsigned w,
                                    int unsigned h);
    if (piece_cnt >= FreeDepth) begin
      piece_dropped = 1'b1;
      return;
    end
    piece_box[piece_cnt] = '{x, y, w, h};
    piece_ok[piece_cnt]  = 1'b1;
    piece_cnt++;
  endfunction

  // up to four maximal pieces of f left around r
  function automatic void carve(box_t f, box_t r);
    int unsigned fr, fb, rr, rb;
    fr = f.x + f.w; fb = f.y + f.h; rr = r.x + r.w; rb = r.y + r.h;
    if (r.x < fr && rr > f.x) begin
      if (rb < fb) add_piece(f.x, rb, f.w, fb - rb);
      if (r.y > f.y && r.y < fb) add_piece(f.x, f.y, f.w, r.y - f.y);
    end
    if (r.y < fb && rb > f.y) begin
      if (r.x > f.x && r.x < fr) add_piece(f.x, f.y, r.x - f.x, f.h);
      if (rr < fr) add_piece(rr, f.y, fr - rr, f.h);
    end
  endfunction

  // best area fit, shorter leftover side breaks ties; -1 if nothing fits
  function automatic int best_slot(int unsigned w, int unsigned h);
    int unsigned best_area, best_side, area, dw, dh, s;
    int pick;
    best_area = '1; best_side = '1; pick = -1;
    for (int i = 0; i < FreeDepth; i++) begin
      if (!free_ok[i] || w > free_box[i].w || h > free_box[i].h) continue;
      area = free_box[i].w * free_box[i].h - w * h;
      dw = free_box[i].w - w;
      dh = free_box[i].h - h;
      s = (dw < dh) ? dw : dh;
      if (area < best_area) begin
        best_area = area; best_side = s; pick = i;
      end else if (area == best_area && s < best_side) begin
        best_side = s; pick = i;
      end
    end
    return pick;
  endfunction

  // split, prune and compact the free list; 1 when free space was lost
  function automatic bit commit_box(box_t r);
    int unsigned k;
    foreach (piece_ok[i]) piece_ok[i] = 1'b0;
    piece_cnt = 0;
    piece_dropped = 1'b0;
    for (int i = 0; i < FreeDepth; i++)
      if (free_ok[i] && overlaps(free_box[i], r)) begin
        carve(free_box[i], r);
        free_ok[i] = 1'b0;
      end
    for (int i = 0; i < piece_cnt; i++) begin
      if (!piece_ok[i]) continue;
      for (int j = 0; j < piece_cnt; j++)
        if (j != i && piece_ok[j] && covers(piece_box[i], piece_box[j])) piece_ok[j] = 1'b0;
    end
    for (int i = 0; i < FreeDepth; i++) begin
      if (!free_ok[i]) continue;
      for (int j = 0; j < piece_cnt; j++)
        if (piece_ok[j] && covers(free_box[i], piece_box[j])) piece_ok[j] = 1'b0;
    end
    k = 0;
    for (int i = 0; i < FreeDepth; i++)
      if (free_ok[i]) free_box[k++] = free_box[i];
    for (int j = 0; j < piece_cnt; j++) begin
      if (!piece_ok[j]) continue;
      if (k < FreeDepth) free_box[k++] = piece_box[j];
      else piece_dropped = 1'b1;
    end
    for (int i = 0; i < FreeDepth; i++) free_ok[i] = (i < k);
    return piece_dropped;
  endfunction

  function automatic mrp_pkg::out_word_t pack_rect(mrp_pkg::in_word_t wd);
    mrp_pkg::out_word_t res;
    int unsigned        w, h;
    int                 slot;
    bit                 fresh;
    mrp_pkg::status_e   st;
    box_t               r;
    w = wd.rect_width;
    h = wd.rect_height;
    if (w == 0) w = 1;
    if (h == 0) h = 1;
    res = '0;
    fresh = 1'b0;
    if (batch_halted) begin
      st = mrp_pkg::ST_SKIPPED;
    end else begin
      st = mrp_pkg::ST_PLACED;
      slot = best_slot(w, h);
      if (slot < 0) begin
        if (!multi_bin) begin
          st = mrp_pkg::ST_NO_ROOM;
          batch_halted = 1'b1;
        end else begin
          reload_bin();
          if (bin_cnt < 16'hffff) bin_cnt++;
          fresh = 1'b1;
          slot = best_slot(w, h);
          if (slot < 0) st = mrp_pkg::ST_TOO_LARGE;
        end
      end
      if (slot >= 0) begin
        r = '{free_box[slot].x, free_box[slot].y, w, h};
        res.pos_x = r.x[12:0];
        res.pos_y = r.y[12:0];
        st = fresh ? mrp_pkg::ST_NEW_BIN : mrp_pkg::ST_PLACED;
        if (commit_box(r)) st = mrp_pkg::ST_OVERFLOW;
        if (placed_cnt < 24'hffffff) placed_cnt++;
      end
    end
    res.bin_index    = bin_cnt[15:0];
    res.status       = st;
    res.placed_count = placed_cnt[23:0];
    if (wd.end_of_batch) begin
      bin_cnt = 0;
      batch_halted = 1'b0;
    end
    return res;
  endfunction

  // ---- clock, reset, idle pattern ------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int draw_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // ---- driver: feeds size words from the queue -----------------------------

  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (in_valid_i) result_queue = {result_queue, pack_rect(in_word_i)};
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (size_queue.size() > 0) begin
        in_word_i  <= size_queue.pop_front();
        in_valid_i <= 1'b1;
        in_gap = draw_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---- monitor: stalls at random and checks each result word ---------------

  always @(posedge clk_i) begin
    mrp_pkg::out_word_t exp_w;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %p", $time, out_word_o);
          failed = 1'b1;
        end else begin
          exp_w = result_queue.pop_front();
          if (out_word_o.pos_x !== exp_w.pos_x) begin
            $display("%0t: pos_x expected %0d actual %0d", $time, exp_w.pos_x,
                     out_word_o.pos_x);
            failed = 1'b1;
          end
          if (out_word_o.pos_y !== exp_w.pos_y) begin
            $display("%0t: pos_y expected %0d actual %0d", $time, exp_w.pos_y,
                     out_word_o.pos_y);
            failed = 1'b1;
          end
          if (out_word_o.bin_index !== exp_w.bin_index) begin
            $display("%0t: bin_index expected %0d actual %0d", $time, exp_w.bin_index,
                     out_word_o.bin_index);
            failed = 1'b1;
          end
          if (out_word_o.status !== exp_w.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_w.status,
                     out_word_o.status);
            failed = 1'b1;
          end
          if (out_word_o.placed_count !== exp_w.placed_count) begin
            $display("%0t: placed_count expected %0d actual %0d", $time,
                     exp_w.placed_count, out_word_o.placed_count);
            failed = 1'b1;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        out_gap = draw_gap();
      end
    end
  end

  // ---- watchdog: cycles with no handshake on any channel -------------------

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---- stimulus ------------------------------------------------------------

  // block is idle once every queued word has come back
  task automatic drain();
    do @(posedge clk_i);
    while (size_queue.size() > 0 || in_valid_i || result_queue.size() > 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [mrp_pkg::CfgIdxBits-1:0] idx, int unsigned data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data[mrp_pkg::FieldDimBits-1:0];
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      mrp_pkg::CFG_BIN_WIDTH: begin
        bin_w = clamp_dim(data);
        reload_bin();
      end
      mrp_pkg::CFG_BIN_HEIGHT: begin
        bin_h = clamp_dim(data);
        reload_bin();
      end
      mrp_pkg::CFG_MULTIPLE_BINS: multi_bin = data[0];
      default: ;
    endcase
    // wait with cfg_valid_i low so the next write starts in a later time step
    @(posedge clk_i);
  endtask

  task automatic add_size(int unsigned w, int unsigned h, bit eob);
    mrp_pkg::in_word_t wd;
    wd.rect_width   = w[mrp_pkg::FieldDimBits-1:0];
    wd.rect_height  = h[mrp_pkg::FieldDimBits-1:0];
    wd.end_of_batch = eob;
    size_queue = {size_queue, wd};
  endtask

  // random batch: sizes mostly small against the bin, some wild ones
  task automatic random_sizes(int n);
    int unsigned w, h, r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        w = $urandom_range(0, DimMask);
        h = $urandom_range(0, DimMask);
      end else if (r == 1) begin
        w = 0;
        h = $urandom_range(0, 3);
      end else if (r < 5) begin
        w = $urandom_range(1, bin_w);
        h = $urandom_range(1, bin_h);
      end else begin
        w = $urandom_range(1, bin_w / 6 + 1);
        h = $urandom_range(1, bin_h / 6 + 1);
      end
      add_size(w, h, $urandom_range(0, 14) == 0);
    end
    drain();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = mrp_pkg::CFG_BIN_WIDTH;
    cfg_data_i  = '0;
    in_gap      = 0;
    out_gap     = 0;
    idle_cycles = 0;
    failed      = 1'b0;
    // reset state
    bin_w = 1024; bin_h = 1024; multi_bin = 1'b0;
    bin_cnt = 0; placed_cnt = 0; batch_halted = 1'b0;
    foreach (piece_ok[i]) piece_ok[i] = 1'b0;
    reload_bin();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single bin: exact fill, then no room, skipped words until end of batch
    add_size(1024, 1024, 1'b0);
    add_size(1, 1, 1'b0);
    add_size(16383, 16383, 1'b1);
    // zero sizes count as one, all-ones size never fits
    add_size(0, 0, 1'b0);
    add_size(16383, 16383, 1'b1);
    add_size(0, 5, 1'b0);
    add_size(1023, 1, 1'b1);
    drain();

    // multi-bin: too large keeps the fresh bin, then a new bin placement
    reg_write(mrp_pkg::CFG_MULTIPLE_BINS, 1);
    add_size(9000, 4, 1'b0);
    add_size(512, 512, 1'b0);
    add_size(1024, 1024, 1'b0);
    add_size(10, 10, 1'b1);
    drain();

    // smallest bin, then largest after saturation of an oversized write
    reg_write(mrp_pkg::CFG_BIN_WIDTH, 0);
    reg_write(mrp_pkg::CFG_BIN_HEIGHT, 0);
    reg_write(CFG_UNUSED, 16383);
    add_size(1, 1, 1'b0);
    add_size(1, 1, 1'b0);
    add_size(2, 1, 1'b1);
    drain();
    reg_write(mrp_pkg::CFG_BIN_WIDTH, 16383);
    reg_write(mrp_pkg::CFG_BIN_HEIGHT, 8192);
    add_size(8192, 8192, 1'b0);
    add_size(8193, 1, 1'b0);
    add_size(3, 7, 1'b1);
    drain();

    // random phases over several bin settings; many small pieces in a big
    // bin push the free list toward overflow
    random_sizes(70);
    reg_write(mrp_pkg::CFG_BIN_WIDTH, 64);
    reg_write(mrp_pkg::CFG_BIN_HEIGHT, 48);
    random_sizes(60);
    reg_write(mrp_pkg::CFG_MULTIPLE_BINS, 0);
    reg_write(mrp_pkg::CFG_BIN_WIDTH, 1024);
    reg_write(mrp_pkg::CFG_BIN_HEIGHT, 1024);
    random_sizes(60);
    reg_write(mrp_pkg::CFG_MULTIPLE_BINS, 1);
    reg_write(mrp_pkg::CFG_BIN_WIDTH, $urandom_range(2, 300));
    reg_write(mrp_pkg::CFG_BIN_HEIGHT, $urandom_range(2, 300));
    random_sizes(50);
    reg_write(mrp_pkg::CFG_BIN_WIDTH, 1);
    random_sizes(20);
    drain();
    repeat (200) @(posedge clk_i);

    if (!failed) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
